>>> sv/mtg_pkg.sv
package mtg_pkg;

    // State array geometry
    localparam int STATE_WORDS = 624;
    localparam int IDX_W       = 10;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [31:0]      t_word;

    localparam t_idx LAST_IDX     = t_idx'(STATE_WORDS - 1);
    localparam t_idx TWIST_OFFSET = 10'd397;
    localparam t_idx TWIST_WRAP   = t_idx'(STATE_WORDS - 397);

    // Twist, tempering and seeding constants
    localparam t_word MATRIX_A   = 32'h9908_B0DF;
    localparam t_word UPPER_BIT  = 32'h8000_0000;
    localparam t_word LOWER_BITS = 32'h7FFF_FFFF;
    localparam t_word TEMPER_B   = 32'h9D2C_5680;
    localparam t_word TEMPER_C   = 32'hEFC6_0000;
    localparam t_word SEED_MULT  = 32'd69069;
    localparam t_word SEED_RESET = 32'd5489;

    // Queue status seen by the neighbor of a queue
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SEED  = 4'b0010,
        S_READ  = 4'b0100,
        S_TWIST = 4'b1000
    } t_eng_state;

endpackage

>>> sv/mtg_fifo.sv
module mtg_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd,
    output logic [WIDTH-1:0]     o_rd_data,
    output mtg_pkg::t_q_status   o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slots [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             wr_ok, rd_ok;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign wr_ok          = i_wr && !o_status.full;
    assign rd_ok          = i_rd && !o_status.empty;
    assign o_rd_data      = r_slots[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_count = r_count + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_slots[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

>>> sv/mtg_engine.sv
module mtg_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mtg_pkg::t_q_status   i_req_status,
    input  logic                 i_req_reseed,
    input  mtg_pkg::t_word       i_seed_value,
    input  mtg_pkg::t_q_status   i_res_status,
    output logic                 o_req_take,
    output logic                 o_res_push,
    output mtg_pkg::t_word       o_res_word
);

    function automatic mtg_pkg::t_word temper(input mtg_pkg::t_word w);
        mtg_pkg::t_word t;
        t = w ^ (w >> 11);
        t = t ^ ((t << 7) & mtg_pkg::TEMPER_B);
        t = t ^ ((t << 15) & mtg_pkg::TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    mtg_pkg::t_word      r_words [mtg_pkg::STATE_WORDS];

    mtg_pkg::t_eng_state r_state, n_state;
    mtg_pkg::t_idx       r_pos, n_pos;
    logic                r_seeded, n_seeded;
    mtg_pkg::t_word      r_seed_word, n_seed_word;
    mtg_pkg::t_word      r_cur, n_cur;
    mtg_pkg::t_word      r_rd_a, r_rd_b;

    mtg_pkg::t_idx       addr_a, addr_b;
    mtg_pkg::t_word      seed_prod, twist_y, twist_v;
    logic                mem_we;
    mtg_pkg::t_idx       mem_waddr;
    mtg_pkg::t_word      mem_wdata;

    assign seed_prod = r_seed_word * mtg_pkg::SEED_MULT;
    assign addr_a    = (r_pos == mtg_pkg::LAST_IDX) ? '0 : r_pos + 1'b1;
    assign addr_b    = (r_pos >= mtg_pkg::TWIST_WRAP) ? r_pos - mtg_pkg::TWIST_WRAP
                                                      : r_pos + mtg_pkg::TWIST_OFFSET;
    assign twist_y   = (r_cur & mtg_pkg::UPPER_BIT) | (r_rd_a & mtg_pkg::LOWER_BITS);
    assign twist_v   = r_rd_b ^ (twist_y >> 1) ^ (twist_y[0] ? mtg_pkg::MATRIX_A : '0);
    assign o_res_word = temper(twist_v);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_seeded    = r_seeded;
        n_seed_word = r_seed_word;
        n_cur       = r_cur;
        o_req_take  = 1'b0;
        o_res_push  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_seed_word;
        case (r_state)
            mtg_pkg::S_IDLE: begin
                if (!i_req_status.empty && !i_res_status.full) begin
                    o_req_take = 1'b1;
                    if (i_req_reseed || !r_seeded) begin
                        n_state     = mtg_pkg::S_SEED;
                        n_pos       = '0;
                        n_seed_word = i_seed_value;
                    end else begin
                        n_state = mtg_pkg::S_READ;
                    end
                end
            end
            mtg_pkg::S_SEED: begin
                mem_we      = 1'b1;
                n_seed_word = seed_prod;
                if (r_pos == '0) begin
                    n_cur = r_seed_word;
                end
                if (r_pos == mtg_pkg::LAST_IDX) begin
                    n_state  = mtg_pkg::S_READ;
                    n_pos    = '0;
                    n_seeded = 1'b1;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            mtg_pkg::S_READ: begin
                n_state = mtg_pkg::S_TWIST;
            end
            mtg_pkg::S_TWIST: begin
                mem_we     = 1'b1;
                mem_wdata  = twist_v;
                o_res_push = 1'b1;
                n_cur      = r_rd_a;
                n_pos      = addr_a;
                n_state    = mtg_pkg::S_IDLE;
            end
            default: begin
                n_state = mtg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mtg_pkg::S_IDLE;
            r_pos    <= '0;
            r_seeded <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_seeded <= n_seeded;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed_word <= n_seed_word;
        r_cur       <= n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_words[mem_waddr] <= mem_wdata;
        end
        if (r_state == mtg_pkg::S_READ) begin
            r_rd_a <= r_words[addr_a];
            r_rd_b <= r_words[addr_b];
        end
    end

endmodule

>>> sv/mersenne_twister_generator.sv
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+----------------------------
// request   | in        | push / full               | i_reseed
// result    | out       | empty / pop               | o_random_word
// seed cfg  | in        | i_cfg_valid / o_cfg_ready | i_seed_value
//
// A draw passes through the engine states idle, read and twist: idle takes the
// request, read does the two state-memory reads, twist twists, writes back and tempers.
// A seeding draw also fills all 624 state words first, one state word per cycle
// through the 69069 multiplier; the first request after reset always seeds.
// Reset clears control and queues and loads the seed register with 5489;
// the state memory is left unwritten until the first seeding.
// A full result queue holds the engine in idle; a full request queue stalls push.

module mersenne_twister_generator #(
    parameter int REQ_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  logic        i_reseed,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_random_word,
    // seed register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_seed_value
);

    mtg_pkg::t_word     r_seed_value;
    mtg_pkg::t_q_status req_status, res_status;
    logic               req_reseed;
    logic               req_take;
    logic               res_push;
    mtg_pkg::t_word     res_word;

    // The seed register is always ready; a new seed waits for the next seeding.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_value <= mtg_pkg::SEED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed_value <= i_seed_value;
        end
    end

    // Front: queue incoming requests so the caller need not wait on a twist while the queue has room.
    mtg_fifo #(
        .WIDTH (1),
        .DEPTH (REQ_DEPTH)
    ) u_req_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (i_reseed),
        .i_rd      (req_take),
        .o_rd_data (req_reseed),
        .o_status  (req_status)
    );

    assign full = req_status.full;

    // Back: seed, twist one word per draw, temper.
    mtg_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_status (req_status),
        .i_req_reseed (req_reseed),
        .i_seed_value (r_seed_value),
        .i_res_status (res_status),
        .o_req_take   (req_take),
        .o_res_push   (res_push),
        .o_res_word   (res_word)
    );

    // Results wait here so the engine can take the next request under a stall.
    mtg_fifo #(
        .WIDTH (32),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_push),
        .i_wr_data (res_word),
        .i_rd      (pop),
        .o_rd_data (o_random_word),
        .o_status  (res_status)
    );

    assign empty = res_status.empty;

endmodule

>>> sv/mtg_checker.sv
module mtg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_random_word
);

    logic [7:0] r_pending;
    logic       push_ok, pop_ok;

    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    // Requests transferred in whose result has not yet been transferred out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (push_ok && !pop_ok) begin
            r_pending <= r_pending + 1'b1;
        end else if (pop_ok && !push_ok) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_pending != 8'd0))
        else $error("result shown without an outstanding request");

    a_result_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result dropped");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable(o_random_word))
        else $error("stalled result changed");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);
